>>> rtl/psst_pkg.sv
package psst_pkg;

   // command codes carried in req_tuser; code 7 is unused and falls to a default arm
   typedef enum logic [2:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_BACK  = 3'd1,
      CMD_DEL_FRONT = 3'd2,
      CMD_DEL_BACK  = 3'd3,
      CMD_INS_AT    = 3'd4,
      CMD_DEL_AT    = 3'd5,
      CMD_DUMP      = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BADPOS = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SH_RD,
      S_SH_WR,
      S_PUT,
      S_RESP,
      S_DUMP_RD,
      S_DUMP_OUT
   } state_type;

   // controller -> datapath strobes
   typedef struct packed {
      logic load;
      logic decode;
      logic rd_shift;
      logic wr_shift;
      logic put;
      logic dec_occ;
      logic emit_status;
      logic dump_rd;
      logic dump_emit;
   } ctrl_cmd_type;

   // datapath -> controller flags
   typedef struct packed {
      logic go_insert;
      logic go_delete;
      logic go_dump;
      logic shift_more;
      logic shift_ins;
      logic dump_last;
      logic out_free;
   } dp_status_type;

endpackage

>>> rtl/psst_ram.sv
module psst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/psst_ctrl.sv
module psst_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  psst_pkg::dp_status_type stat,
   output psst_pkg::ctrl_cmd_type  ctrl
);

   psst_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= psst_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         psst_pkg::S_IDLE: begin
            if (req_tvalid) state_in = psst_pkg::S_DECODE;
         end
         psst_pkg::S_DECODE: begin
            if (stat.go_insert || stat.go_delete) state_in = psst_pkg::S_SH_RD;
            else if (stat.go_dump) state_in = psst_pkg::S_DUMP_RD;
            else state_in = psst_pkg::S_RESP;
         end
         psst_pkg::S_SH_RD: begin
            if (stat.shift_more) state_in = psst_pkg::S_SH_WR;
            else if (stat.shift_ins) state_in = psst_pkg::S_PUT;
            else state_in = psst_pkg::S_RESP;
         end
         psst_pkg::S_SH_WR:  state_in = psst_pkg::S_SH_RD;
         psst_pkg::S_PUT:    state_in = psst_pkg::S_RESP;
         psst_pkg::S_RESP: begin
            if (stat.out_free) state_in = psst_pkg::S_IDLE;
         end
         psst_pkg::S_DUMP_RD: state_in = psst_pkg::S_DUMP_OUT;
         psst_pkg::S_DUMP_OUT: begin
            if (stat.out_free) begin
               state_in = stat.dump_last ? psst_pkg::S_IDLE : psst_pkg::S_DUMP_RD;
            end
         end
         default: state_in = psst_pkg::S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl       = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         psst_pkg::S_IDLE: begin
            req_tready = 1'b1;
            ctrl.load  = req_tvalid;
         end
         psst_pkg::S_DECODE: ctrl.decode = 1'b1;
         psst_pkg::S_SH_RD: begin
            ctrl.rd_shift = stat.shift_more;
            ctrl.dec_occ  = !stat.shift_more && !stat.shift_ins;
         end
         psst_pkg::S_SH_WR:    ctrl.wr_shift    = 1'b1;
         psst_pkg::S_PUT:      ctrl.put         = 1'b1;
         psst_pkg::S_RESP:     ctrl.emit_status = stat.out_free;
         psst_pkg::S_DUMP_RD:  ctrl.dump_rd     = 1'b1;
         psst_pkg::S_DUMP_OUT: ctrl.dump_emit   = stat.out_free;
         default: ;
      endcase
   end

endmodule

>>> rtl/psst_datapath.sv
module psst_datapath #(
   parameter int CAPACITY = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  psst_pkg::ctrl_cmd_type  ctrl,
   output psst_pkg::dp_status_type stat,
   input  logic [39:0]             req_tdata,
   input  logic [2:0]              req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [39:0]             rsp_tdata,
   output logic [1:0]              rsp_tuser,
   output logic                    rsp_tlast
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (AW + 2 > 7) ? AW + 2 : 7;

   logic [2:0]           cmd_ff, cmd_in;
   logic [31:0]          value_ff, value_in;
   logic [5:0]           pos_ff, pos_in;
   logic [CW-1:0]        occ_ff, occ_in;
   logic [AW-1:0]        cur_ff, cur_in;
   logic [AW-1:0]        tgt_ff, tgt_in;
   logic                 ins_ff, ins_in;
   psst_pkg::status_type st_ff, st_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          item_ff, item_in;
   logic [5:0]           count_ff, count_in;
   psst_pkg::status_type rstat_ff, rstat_in;
   logic                 last_ff, last_in;

   logic [XW-1:0]        occ_x, pos_x, cur_x, tgt_x, idx_x;
   logic                 full, empty;
   psst_pkg::status_type dec_st;
   logic                 dec_ins, dec_del, dec_dump;
   logic [AW-1:0]        dec_idx;

   logic                 ram_we, ram_re;
   logic [AW-1:0]        ram_waddr, ram_raddr;
   logic [31:0]          ram_wdata, ram_rdata;

   assign occ_x = XW'(occ_ff);
   assign pos_x = XW'(pos_ff);
   assign cur_x = XW'(cur_ff);
   assign tgt_x = XW'(tgt_ff);
   assign full  = (occ_ff == CW'(CAPACITY));
   assign empty = (occ_ff == '0);

   // command decode against the current count
   always_comb begin
      dec_st   = psst_pkg::ST_OK;
      dec_ins  = 1'b0;
      dec_del  = 1'b0;
      dec_dump = 1'b0;
      idx_x    = '0;
      unique case (psst_pkg::cmd_type'(cmd_ff))
         psst_pkg::CMD_INS_FRONT: begin
            if (full) dec_st = psst_pkg::ST_FULL;
            else dec_ins = 1'b1;
         end
         psst_pkg::CMD_INS_BACK: begin
            idx_x = occ_x;
            if (full) dec_st = psst_pkg::ST_FULL;
            else dec_ins = 1'b1;
         end
         psst_pkg::CMD_DEL_FRONT: begin
            if (empty) dec_st = psst_pkg::ST_EMPTY;
            else dec_del = 1'b1;
         end
         psst_pkg::CMD_DEL_BACK: begin
            idx_x = occ_x - XW'(1);
            if (empty) dec_st = psst_pkg::ST_EMPTY;
            else dec_del = 1'b1;
         end
         psst_pkg::CMD_INS_AT: begin
            idx_x = pos_x - XW'(1);
            if (pos_x == '0 || pos_x > occ_x + XW'(1)) dec_st = psst_pkg::ST_BADPOS;
            else if (full) dec_st = psst_pkg::ST_FULL;
            else dec_ins = 1'b1;
         end
         psst_pkg::CMD_DEL_AT: begin
            idx_x = pos_x - XW'(1);
            if (pos_x == '0 || pos_x > occ_x) dec_st = psst_pkg::ST_BADPOS;
            else dec_del = 1'b1;
         end
         psst_pkg::CMD_DUMP: begin
            if (empty) dec_st = psst_pkg::ST_EMPTY;
            else dec_dump = 1'b1;
         end
         default: ;
      endcase
   end

   assign dec_idx = idx_x[AW-1:0];

   assign stat.go_insert  = dec_ins;
   assign stat.go_delete  = dec_del;
   assign stat.go_dump    = dec_dump;
   assign stat.shift_ins  = ins_ff;
   assign stat.shift_more = ins_ff ? (cur_x > tgt_x) : (cur_x + XW'(1) < occ_x);
   assign stat.dump_last  = (cur_x + XW'(1) == occ_x);
   assign stat.out_free   = !rsp_valid_ff || rsp_tready;

   // insert shifts toward the back (read cur-1, write cur), delete toward the front
   assign ram_re    = ctrl.rd_shift || ctrl.dump_rd;
   assign ram_raddr = ctrl.dump_rd ? cur_ff :
                      (ins_ff ? cur_ff - AW'(1) : cur_ff + AW'(1));
   assign ram_we    = ctrl.wr_shift || ctrl.put;
   assign ram_waddr = ctrl.put ? tgt_ff : cur_ff;
   assign ram_wdata = ctrl.put ? value_ff : ram_rdata;

   psst_ram #(
      .WIDTH(32),
      .DEPTH(CAPACITY)
   ) u_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (ram_re),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   always_comb begin
      cmd_in   = cmd_ff;
      value_in = value_ff;
      pos_in   = pos_ff;
      occ_in   = occ_ff;
      cur_in   = cur_ff;
      tgt_in   = tgt_ff;
      ins_in   = ins_ff;
      st_in    = st_ff;
      if (ctrl.load) begin
         cmd_in   = req_tuser;
         value_in = req_tdata[31:0];
         pos_in   = req_tdata[37:32];
      end
      if (ctrl.decode) begin
         cur_in = dec_ins ? AW'(occ_ff) : dec_idx;
         tgt_in = dec_idx;
         ins_in = dec_ins;
         st_in  = dec_st;
      end
      if (ctrl.wr_shift) cur_in = ins_ff ? cur_ff - AW'(1) : cur_ff + AW'(1);
      if (ctrl.dump_emit) cur_in = cur_ff + AW'(1);
      if (ctrl.put) occ_in = occ_ff + CW'(1);
      if (ctrl.dec_occ) occ_in = occ_ff - CW'(1);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      item_in      = item_ff;
      count_in     = count_ff;
      rstat_in     = rstat_ff;
      last_in      = last_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (ctrl.emit_status) begin
         rsp_valid_in = 1'b1;
         item_in      = '0;
         count_in     = 6'(occ_ff);
         rstat_in     = st_ff;
         last_in      = 1'b1;
      end
      if (ctrl.dump_emit) begin
         rsp_valid_in = 1'b1;
         item_in      = ram_rdata;
         count_in     = 6'(occ_ff);
         rstat_in     = psst_pkg::ST_OK;
         last_in      = stat.dump_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      value_ff <= value_in;
      pos_ff   <= pos_in;
      cur_ff   <= cur_in;
      tgt_ff   <= tgt_in;
      ins_ff   <= ins_in;
      st_ff    <= st_in;
      item_ff  <= item_in;
      count_ff <= count_in;
      rstat_ff <= rstat_in;
      last_ff  <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, count_ff, item_ff};
   assign rsp_tuser  = rstat_ff;
   assign rsp_tlast  = last_ff;

endmodule

>>> rtl/positional_sequence_store_top.sv
// Sequence per request: IDLE accepts, DECODE checks it; a rejected or no-op request goes to RESP.
//   Insert and delete move m entries (count-p for delete at p, count-p+1 for insert at p,
//   count taken before the request), then PUT for an insert; a dump reads and emits each entry.
// Throughput: one request at a time; each entry move is a RAM read then a write, and a
//   dump emits one response per entry read. Response back-pressure stalls RESP and DUMP_OUT.
// Reset: synchronous, active high; clears count and response valid, not the entry RAM.
module positional_sequence_store_top #(
   parameter int CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // [31:0] value, [37:32] position, [39:38] zero
   input  logic [2:0]  req_tuser,  // [2:0] cmd
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // [31:0] item_value, [37:32] entry_count, [39:38] zero
   output logic [1:0]  rsp_tuser,  // [1:0] status
   output logic        rsp_tlast   // final response of a request
);

   // Controller sequences each request; datapath holds count, cursor, entry RAM
   // and the response register, so a finished response can sit while the
   // controller returns to IDLE for the next request.
   psst_pkg::ctrl_cmd_type  ctrl;
   psst_pkg::dp_status_type stat;

   psst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   psst_datapath #(
      .CAPACITY(CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .stat      (stat),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   // an accepted request is decoded on the very next cycle
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> ctrl.decode)
      else $error("request accepted but not decoded");

   // the controller issues at most one datapath strobe per cycle
   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      $onehot0(ctrl))
      else $error("multiple datapath strobes");

   // any error status ends the request's responses
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != psst_pkg::ST_OK) |-> rsp_tlast)
      else $error("error response without last");

   // no new request while a multi-step one is in flight
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (ctrl.rd_shift || ctrl.wr_shift || ctrl.dump_rd) |-> !req_tready)
      else $error("ready raised during command");

endmodule

>>> tb/positional_sequence_store_top_tb.sv
`timescale 1ns / 100ps

module positional_sequence_store_top_tb;

   localparam int CAPACITY = 32;
   localparam int RANDOM_ITEMS = 86;
   localparam int IDLE_PCT = 27;
   // code 7 has no enum member; the block treats it as a no-op
   localparam logic [2:0] CMD_UNUSED = 3'd7;

   // one response as it appears on the rsp_ channel
   typedef struct packed {
      logic [31:0]          item_value;
      logic [5:0]           entry_count;
      psst_pkg::status_type status;
      logic                 last;
   } store_rsp_type;

   // one row of the directed table; typed rows carry a hand-written response
   typedef struct packed {
      logic [2:0]           cmd;
      logic [31:0]          value;
      logic [5:0]           pos;
      logic                 typed;
      psst_pkg::status_type status;
      logic [5:0]           cnt;
   } dir_row_type;

   localparam int NUM_DIRECTED = 23;
   localparam dir_row_type DIRECTED [NUM_DIRECTED] = '{
      // empty store: every delete, the dump and out-of-range insert-at report empty or bad position
      '{psst_pkg::CMD_DUMP,      32'h0000_0000, 6'd0,  1'b1, psst_pkg::ST_EMPTY,  6'd0},
      '{psst_pkg::CMD_DEL_FRONT, 32'h0000_0000, 6'd0,  1'b1, psst_pkg::ST_EMPTY,  6'd0},
      '{psst_pkg::CMD_DEL_BACK,  32'h0000_0000, 6'd0,  1'b1, psst_pkg::ST_EMPTY,  6'd0},
      '{psst_pkg::CMD_DEL_AT,    32'h0000_0000, 6'd1,  1'b1, psst_pkg::ST_BADPOS, 6'd0},
      '{psst_pkg::CMD_INS_AT,    32'h1234_5678, 6'd0,  1'b1, psst_pkg::ST_BADPOS, 6'd0},
      '{psst_pkg::CMD_INS_AT,    32'h1234_5678, 6'd2,  1'b1, psst_pkg::ST_BADPOS, 6'd0},
      // value extremes, insert at the middle and at count+1
      '{psst_pkg::CMD_INS_FRONT, 32'h7FFF_FFFF, 6'd0,  1'b1, psst_pkg::ST_OK,     6'd1},
      '{psst_pkg::CMD_INS_BACK,  32'h8000_0000, 6'd0,  1'b1, psst_pkg::ST_OK,     6'd2},
      '{psst_pkg::CMD_INS_AT,    32'h0000_0000, 6'd2,  1'b0, psst_pkg::ST_OK,     6'd0},
      '{psst_pkg::CMD_INS_AT,    32'hFFFF_FFFF, 6'd4,  1'b0, psst_pkg::ST_OK,     6'd0},
      '{psst_pkg::CMD_INS_AT,    32'h5555_5555, 6'd63, 1'b1, psst_pkg::ST_BADPOS, 6'd4},
      '{psst_pkg::CMD_INS_AT,    32'hAAAA_AAAA, 6'd1,  1'b0, psst_pkg::ST_OK,     6'd0},
      '{psst_pkg::CMD_DUMP,      32'h0000_0000, 6'd0,  1'b0, psst_pkg::ST_OK,     6'd0},
      // unused code leaves the store alone
      '{CMD_UNUSED,              32'hFFFF_FFFF, 6'd63, 1'b1, psst_pkg::ST_OK,     6'd5},
      '{psst_pkg::CMD_DEL_AT,    32'h0000_0000, 6'd63, 1'b1, psst_pkg::ST_BADPOS, 6'd5},
      '{psst_pkg::CMD_DEL_AT,    32'h0000_0000, 6'd0,  1'b1, psst_pkg::ST_BADPOS, 6'd5},
      '{psst_pkg::CMD_DEL_AT,    32'h0000_0000, 6'd5,  1'b0, psst_pkg::ST_OK,     6'd0},
      '{psst_pkg::CMD_DEL_AT,    32'h0000_0000, 6'd2,  1'b0, psst_pkg::ST_OK,     6'd0},
      '{psst_pkg::CMD_DEL_FRONT, 32'h0000_0000, 6'd0,  1'b0, psst_pkg::ST_OK,     6'd0},
      '{psst_pkg::CMD_DEL_BACK,  32'h0000_0000, 6'd0,  1'b0, psst_pkg::ST_OK,     6'd0},
      '{psst_pkg::CMD_DUMP,      32'h0000_0000, 6'd0,  1'b0, psst_pkg::ST_OK,     6'd0},
      '{psst_pkg::CMD_DEL_AT,    32'h0000_0000, 6'd1,  1'b0, psst_pkg::ST_OK,     6'd0},
      '{psst_pkg::CMD_DUMP,      32'h0000_0000, 6'd0,  1'b1, psst_pkg::ST_EMPTY,  6'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // [31:0] value, [37:32] position, [39:38] zero
   logic [2:0]  req_tuser = '0;   // [2:0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // [31:0] item_value, [37:32] entry_count, [39:38] zero
   logic [1:0]  rsp_tuser;        // [1:0] status
   logic        rsp_tlast;

   // shadow copy of the stored sequence, front at index 0
   logic [31:0]   stored_seq[$];
   // responses produced by the last request applied to the shadow copy
   store_rsp_type predicted[$];
   // responses still owed by the block, oldest first
   store_rsp_type pending_rsp[$];
   int            mismatch_count = 0;
   // set for the long stretch in which neither side idles
   bit            steady = 1'b0;

   positional_sequence_store_top #(.CAPACITY(CAPACITY)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // hard stop well past the slowest legal run
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Apply one request to the shadow sequence and fill predicted[].
   // Insert-at checks the position before the full test.
   function automatic void store_model_apply(input logic [2:0] cmd, input logic [31:0] value,
                                             input logic [5:0] pos);
      int                   n;
      psst_pkg::status_type st;
      n = stored_seq.size();
      st = psst_pkg::ST_OK;
      predicted.delete();
      case (cmd)
         psst_pkg::CMD_INS_FRONT: begin
            if (n >= CAPACITY) st = psst_pkg::ST_FULL;
            else stored_seq.push_front(value);
         end
         psst_pkg::CMD_INS_BACK: begin
            if (n >= CAPACITY) st = psst_pkg::ST_FULL;
            else stored_seq.push_back(value);
         end
         psst_pkg::CMD_DEL_FRONT: begin
            if (n == 0) st = psst_pkg::ST_EMPTY;
            else void'(stored_seq.pop_front());
         end
         psst_pkg::CMD_DEL_BACK: begin
            if (n == 0) st = psst_pkg::ST_EMPTY;
            else void'(stored_seq.pop_back());
         end
         psst_pkg::CMD_INS_AT: begin
            if (pos < 1 || pos > n + 1) st = psst_pkg::ST_BADPOS;
            else if (n >= CAPACITY) st = psst_pkg::ST_FULL;
            else stored_seq.insert(int'(pos) - 1, value);
         end
         psst_pkg::CMD_DEL_AT: begin
            if (pos < 1 || pos > n) st = psst_pkg::ST_BADPOS;
            else stored_seq.delete(int'(pos) - 1);
         end
         psst_pkg::CMD_DUMP: begin
            if (n == 0) st = psst_pkg::ST_EMPTY;
            else begin
               for (int i = 0; i < n; i++)
                  predicted.push_back('{stored_seq[i], 6'(n), psst_pkg::ST_OK, i == n - 1});
               return;
            end
         end
         default: ;
      endcase
      predicted.push_back('{32'h0, 6'(stored_seq.size()), st, 1'b1});
   endfunction

   // Present one request, wait for the handshake, then log what it owes.
   // Valid is only lowered when an idle gap is taken, so back-to-back requests
   // keep it high across the edge.
   task automatic issue_request(input logic [2:0] cmd, input logic [31:0] value,
                                input logic [5:0] pos, input logic typed,
                                input psst_pkg::status_type typed_status,
                                input logic [5:0] typed_cnt);
      int gap;
      if (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         req_tdata <= 40'({$urandom, $urandom});
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, pos, value};
      req_tuser <= cmd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // request taken at this edge
      store_model_apply(cmd, value, pos);
      if (typed) pending_rsp.push_back('{32'h0, typed_cnt, typed_status, 1'b1});
      else foreach (predicted[i]) pending_rsp.push_back(predicted[i]);
   endtask

   // response side: random back-pressure, check each accepted response
   always @(posedge clock) begin
      store_rsp_type got, want;
      rsp_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[31:0], rsp_tdata[37:32], psst_pkg::status_type'(rsp_tuser),
                 rsp_tlast};
         if (pending_rsp.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected response: value %h count %0d status %0d last %b",
                     $time, got.item_value, got.entry_count, got.status, got.last);
         end else begin
            want = pending_rsp.pop_front();
            if (got.item_value !== want.item_value || got.entry_count !== want.entry_count ||
                got.status !== want.status || got.last !== want.last) begin
               mismatch_count++;
               $display("%0t: mismatch: expected value %h count %0d status %0d last %b",
                        $time, want.item_value, want.entry_count, want.status, want.last);
               $display("%0t:           actual value %h count %0d status %0d last %b",
                        $time, got.item_value, got.entry_count, got.status, got.last);
            end
         end
      end
   end

   initial begin
      logic [2:0]  cmd;
      logic [5:0]  pos;
      int          n, lim, kind;
      bit          growing;
      growing = 1'b0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (DIRECTED[i])
         issue_request(DIRECTED[i].cmd, DIRECTED[i].value, DIRECTED[i].pos,
                       DIRECTED[i].typed, DIRECTED[i].status, DIRECTED[i].cnt);

      // long stretch with no idling: fill to capacity, hit the full cases
      steady = 1'b1;
      while (stored_seq.size() < CAPACITY) begin
         kind = $urandom_range(0, 2);
         case (kind)
            0: cmd = psst_pkg::CMD_INS_FRONT;
            1: cmd = psst_pkg::CMD_INS_BACK;
            default: cmd = psst_pkg::CMD_INS_AT;
         endcase
         issue_request(cmd, $urandom, 6'($urandom_range(1, stored_seq.size() + 1)),
                       1'b0, psst_pkg::ST_OK, 6'd0);
      end
      // full
      issue_request(psst_pkg::CMD_INS_AT, $urandom, 6'(CAPACITY + 1), 1'b0,
                    psst_pkg::ST_OK, 6'd0);
      // bad pos
      issue_request(psst_pkg::CMD_INS_AT, $urandom, 6'(CAPACITY + 2), 1'b0,
                    psst_pkg::ST_OK, 6'd0);
      issue_request(psst_pkg::CMD_INS_FRONT, $urandom, 6'd0, 1'b0, psst_pkg::ST_OK, 6'd0);
      issue_request(psst_pkg::CMD_INS_BACK, $urandom, 6'd0, 1'b0, psst_pkg::ST_OK, 6'd0);
      issue_request(psst_pkg::CMD_DEL_AT, 32'h0, 6'(CAPACITY + 1), 1'b0,
                    psst_pkg::ST_OK, 6'd0);
      issue_request(psst_pkg::CMD_DUMP, 32'h0, 6'd0, 1'b0, psst_pkg::ST_OK, 6'd0);
      issue_request(psst_pkg::CMD_DEL_AT, 32'h0, 6'(CAPACITY), 1'b0, psst_pkg::ST_OK, 6'd0);
      issue_request(psst_pkg::CMD_INS_AT, $urandom, 6'(CAPACITY), 1'b0,
                    psst_pkg::ST_OK, 6'd0);
      issue_request(psst_pkg::CMD_DEL_AT, 32'h0, 6'd1, 1'b0, psst_pkg::ST_OK, 6'd0);
      steady = 1'b0;

      // random part: count drifts down and up in phases so both ends get visited
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 30 == 0) growing = !growing && (k != 0);
         n = stored_seq.size();
         kind = $urandom_range(0, 99);
         if (kind < 4) cmd = CMD_UNUSED;
         else if (kind < 12) cmd = psst_pkg::CMD_DUMP;
         else begin
            kind = $urandom_range(0, 2);
            if ($urandom_range(0, 99) < (growing ? 70 : 30)) begin
               case (kind)
                  0: cmd = psst_pkg::CMD_INS_FRONT;
                  1: cmd = psst_pkg::CMD_INS_BACK;
                  default: cmd = psst_pkg::CMD_INS_AT;
               endcase
            end else begin
               case (kind)
                  0: cmd = psst_pkg::CMD_DEL_FRONT;
                  1: cmd = psst_pkg::CMD_DEL_BACK;
                  default: cmd = psst_pkg::CMD_DEL_AT;
               endcase
            end
         end
         // mostly legal positions, some noise over the whole field
         lim = (cmd == psst_pkg::CMD_INS_AT) ? n + 1 : n;
         if ((cmd == psst_pkg::CMD_INS_AT || cmd == psst_pkg::CMD_DEL_AT) && lim > 0 &&
             $urandom_range(0, 99) < 85)
            pos = 6'($urandom_range(1, lim));
         else
            pos = 6'($urandom_range(0, 63));
         issue_request(cmd, $urandom, pos, 1'b0, psst_pkg::ST_OK, 6'd0);
      end
      req_tvalid <= 1'b0;

      // drain, then watch for stray responses
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
